>>> rtl/qap_pkg.sv
// Shared types and constants of the quadratic assignment cost evaluator.
// Used by qap_cost_evaluator, qap_mac and qap_seq in this folder; depends on nothing else.
package qap_pkg;

  localparam int IN_TDATA_W  = 32;
  localparam int COST_W      = 48;
  localparam int CFG_DATA_W  = 6;
  localparam int NUM_VARS_RST = 32;

  localparam logic [1:0] MODE_FLOW   = 2'd0;
  localparam logic [1:0] MODE_DIST   = 2'd1;
  localparam logic [1:0] MODE_ASSIGN = 2'd2;

  localparam logic REG_NUM_VARS  = 1'b0;
  localparam logic REG_CHECK_EN  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } qap_state_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic mul;
    logic acc;
  } qap_mac_ctl_t;

endpackage

>>> rtl/qap_cost_evaluator.sv
// Top level of the quadratic assignment cost evaluator.
// Depends on qap_pkg, qap_ram, qap_mac and qap_seq.
//
// Usage: input beats on in_* write one flow entry (mode 0), one distance
// entry (mode 1) or one assignment element (mode 2). An assignment
// element with tlast high starts an evaluation: the sequencer walks all
// n*n position pairs through one multiply-accumulate unit, one pair per
// cycle, fed by the registered read ports of the distance, assignment and
// flow memories. The result beat on out_* appears once all pairs are
// accumulated, and in_tready stays low during the evaluation. When an
// out-of-range location was seen, the result comes at once with cost 0
// and valid 0.
// The result waits in an output register; while it is not taken, in_tready
// stays low. Reset sets num_vars to 32, check_enable to 1 and clears the
// out-of-range flag; the memories are not cleared and must be written
// before they are read. Configuration is written through cfg_*; the user
// must write it only while idle, as the block does not enforce this.
module qap_cost_evaluator
  import qap_pkg::*;
#(
  parameter int MAX_N      = 32,
  parameter int ENTRY_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // mode [1:0], row [6:2], col [11:7], value [27:12], zero [31:28]
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // cost [47:0]
  output logic [COST_W-1:0]     out_tdata,
  // valid_res [0]
  output logic                  out_tuser
);

  localparam int IDX_W     = $clog2(MAX_N);
  localparam int CNT_W     = $clog2(MAX_N + 1);
  localparam int TAB_DEPTH = 1 << (2 * IDX_W);

  logic [CFG_DATA_W-1:0] nv_r;
  logic                  chk_r;
  logic                  oor_r, oor_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [COST_W-1:0]     cost_r;
  logic                  vres_r;

  logic [1:0]  in_mode;
  logic [4:0]  in_row;
  logic [4:0]  in_col;
  logic [15:0] in_value;

  logic [CNT_W-1:0] n_use;
  logic             in_acc;
  logic             wr_ok;
  logic             row_ok;
  logic             val_ok;
  logic             is_assign;
  logic             eval_last;
  logic             oor_any;
  logic             start;
  logic             immediate;
  logic             out_free;
  logic             seq_idle;
  logic             seq_done;
  logic             seq_valid;

  logic [2*IDX_W-1:0]    waddr;
  logic [IDX_W-1:0]      rd_i, rd_j;
  logic [IDX_W-1:0]      pi_q, pj_q;
  logic [ENTRY_BITS-1:0] dist_q, flow_q;
  logic [COST_W-1:0]     acc;
  qap_mac_ctl_t          mac_ctl;

  assign in_mode  = in_tdata[1:0];
  assign in_row   = in_tdata[6:2];
  assign in_col   = in_tdata[11:7];
  assign in_value = in_tdata[27:12];

  always_comb begin
    if (nv_r == '0) begin
      n_use = CNT_W'(1);
    end else if (32'(nv_r) > MAX_N) begin
      n_use = CNT_W'(MAX_N);
    end else begin
      n_use = CNT_W'(nv_r);
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = seq_idle && out_free;
  assign in_acc    = in_tvalid && in_tready;
  assign wr_ok     = (32'(in_row) < MAX_N) && (32'(in_col) < MAX_N);
  assign row_ok    = 32'(in_row) < 32'(n_use);
  assign val_ok    = 32'(in_value) < 32'(n_use);
  assign is_assign = in_acc && (in_mode == MODE_ASSIGN);
  assign eval_last = is_assign && in_tlast;
  assign oor_any   = oor_r || (is_assign && row_ok && !val_ok);
  assign start     = eval_last && !oor_any;
  assign immediate = eval_last && oor_any;
  assign oor_nxt   = eval_last ? 1'b0 : oor_any;
  assign waddr     = {IDX_W'(in_row), IDX_W'(in_col)};

  qap_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TAB_DEPTH)) u_flow (
    .clk   (clk),
    .we    (in_acc && (in_mode == MODE_FLOW) && wr_ok),
    .waddr (waddr),
    .wdata (ENTRY_BITS'(in_value)),
    .raddr ({pi_q, pj_q}),
    .rdata (flow_q)
  );

  qap_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TAB_DEPTH)) u_dist (
    .clk   (clk),
    .we    (in_acc && (in_mode == MODE_DIST) && wr_ok),
    .waddr (waddr),
    .wdata (ENTRY_BITS'(in_value)),
    .raddr ({rd_i, rd_j}),
    .rdata (dist_q)
  );

  qap_ram #(.WIDTH(IDX_W), .DEPTH(MAX_N)) u_asg_i (
    .clk   (clk),
    .we    (is_assign && row_ok && val_ok),
    .waddr (IDX_W'(in_row)),
    .wdata (IDX_W'(in_value)),
    .raddr (rd_i),
    .rdata (pi_q)
  );

  qap_ram #(.WIDTH(IDX_W), .DEPTH(MAX_N)) u_asg_j (
    .clk   (clk),
    .we    (is_assign && row_ok && val_ok),
    .waddr (IDX_W'(in_row)),
    .wdata (IDX_W'(in_value)),
    .raddr (rd_j),
    .rdata (pj_q)
  );

  qap_seq #(.MAX_N(MAX_N)) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .out_free  (out_free),
    .n_use     (n_use),
    .check_en  (chk_r),
    .pj_q      (pj_q),
    .idle      (seq_idle),
    .done      (seq_done),
    .valid_res (seq_valid),
    .rd_i      (rd_i),
    .rd_j      (rd_j),
    .ctl       (mac_ctl)
  );

  qap_mac #(.ENTRY_BITS(ENTRY_BITS)) u_mac (
    .clk    (clk),
    .ctl    (mac_ctl),
    .dist_q (dist_q),
    .flow_q (flow_q),
    .acc    (acc)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (immediate || seq_done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r        <= CFG_DATA_W'(NUM_VARS_RST);
      chk_r       <= 1'b1;
      oor_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_NUM_VARS: nv_r  <= cfg_wdata;
          REG_CHECK_EN: chk_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      oor_r       <= oor_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (immediate) begin
      cost_r <= '0;
      vres_r <= 1'b0;
    end else if (seq_done) begin
      cost_r <= acc;
      vres_r <= seq_valid;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = cost_r;
  assign out_tuser  = vres_r;

endmodule

>>> rtl/qap_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing else.
module qap_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/qap_mac.sv
// Shared multiply-accumulate unit: registers the distance entry, multiplies it
// by the flow entry and adds the product into the cost. Depends on qap_pkg.
module qap_mac
  import qap_pkg::*;
#(
  parameter int ENTRY_BITS = 16
) (
  input  logic                  clk,
  input  qap_mac_ctl_t          ctl,
  input  logic [ENTRY_BITS-1:0] dist_q,
  input  logic [ENTRY_BITS-1:0] flow_q,
  output logic [COST_W-1:0]     acc
);

  logic [ENTRY_BITS-1:0]   d_r;
  logic [2*ENTRY_BITS-1:0] prod_r;
  logic [COST_W-1:0]       acc_r;
  logic [COST_W-1:0]       acc_nxt;

  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (ctl.acc) begin
      acc_nxt = acc_r + COST_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      d_r <= dist_q;
    end
    if (ctl.mul) begin
      prod_r <= d_r * flow_q;
    end
    acc_r <= acc_nxt;
  end

  assign acc = acc_r;

endmodule

>>> rtl/qap_seq.sv
// Evaluation sequencer: walks all position pairs, tracks the read pipeline and
// counts covered locations. Depends on qap_pkg.
module qap_seq
  import qap_pkg::*;
#(
  parameter int MAX_N = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         out_free,
  input  logic [$clog2(MAX_N+1)-1:0]   n_use,
  input  logic                         check_en,
  input  logic [$clog2(MAX_N)-1:0]     pj_q,
  output logic                         idle,
  output logic                         done,
  output logic                         valid_res,
  output logic [$clog2(MAX_N)-1:0]     rd_i,
  output logic [$clog2(MAX_N)-1:0]     rd_j,
  output qap_mac_ctl_t                 ctl
);

  localparam int IDX_W = $clog2(MAX_N);
  localparam int CNT_W = $clog2(MAX_N + 1);

  qap_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] n_m1;
  logic             issue;
  logic             last_pair;
  logic             s1_v_r, s2_v_r, s3_v_r;
  logic             row0_s1_r;
  logic [MAX_N-1:0] cov_r, cov_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign n_m1      = IDX_W'(n_use - CNT_W'(1));
  assign last_pair = (i_r == n_m1) && (j_r == n_m1);

  always_comb begin
    state_nxt = state_r;
    issue     = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        if (last_pair) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!(s1_v_r || s2_v_r || s3_v_r)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    i_nxt = i_r;
    j_nxt = j_r;
    if (start) begin
      i_nxt = '0;
      j_nxt = '0;
    end else if (issue) begin
      if (j_r == n_m1) begin
        j_nxt = '0;
        i_nxt = i_r + IDX_W'(1);
      end else begin
        j_nxt = j_r + IDX_W'(1);
      end
    end
  end

  // Only locations below the size in use count toward coverage.
  always_comb begin
    cov_nxt = cov_r;
    cnt_nxt = cnt_r;
    if (start) begin
      cov_nxt = '0;
      cnt_nxt = '0;
    end else if (s1_v_r && row0_s1_r && (CNT_W'(pj_q) < n_use) && !cov_r[pj_q]) begin
      cov_nxt[pj_q] = 1'b1;
      cnt_nxt       = cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      s3_v_r    <= 1'b0;
      row0_s1_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      s1_v_r    <= issue;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      row0_s1_r <= issue && (i_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    cov_r <= cov_nxt;
    cnt_r <= cnt_nxt;
  end

  assign idle      = (state_r == ST_IDLE);
  assign valid_res = !check_en || (cnt_r == n_use);
  assign rd_i      = i_r;
  assign rd_j      = j_r;
  assign ctl.clear = start;
  assign ctl.load  = s1_v_r;
  assign ctl.mul   = s2_v_r;
  assign ctl.acc   = s3_v_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == ST_IDLE))
    else $error("evaluation started while busy");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !(s1_v_r || s2_v_r || s3_v_r))
    else $error("pipeline busy while idle");

  a_s1_from_run: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $past(state_r == ST_RUN))
    else $error("pair read outside the run phase");

  a_done_drained: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> ((state_r == ST_DONE) && !s3_v_r && out_free))
    else $error("result taken before the accumulator settled");

endmodule

>>> tb/qap_cost_evaluator_monitor.sv
// Monitor for the quadratic assignment cost evaluator: watches the config, input and result
// channels, predicts every result beat and compares it field by field.
// Depends on qap_pkg for the mode codes, register indexes and bus widths.
module qap_cost_evaluator_monitor
  import qap_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  // mode [1:0], row [6:2], col [11:7], value [27:12], zero [31:28]
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  // cost [47:0]
  input  logic [COST_W-1:0]     out_tdata,
  // valid_res [0]
  input  logic                  out_tuser,
  output int                    mismatches,
  output int                    outstanding
);

  localparam int MAX_N = 32;

  typedef struct packed {
    logic [3:0]  spare;
    logic [15:0] value;
    logic [4:0]  col;
    logic [4:0]  row;
    logic [1:0]  mode;
  } qap_beat_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic              valid;
  } qap_result_t;

  logic [15:0]     flow_mem [MAX_N][MAX_N];
  logic [15:0]     dist_mem [MAX_N][MAX_N];
  logic [4:0]      location [MAX_N];
  logic            bad_location;
  logic [5:0]      num_vars;
  logic            check_on;
  qap_result_t     pending_costs [$];

  initial begin
    for (int i = 0; i < MAX_N; i++) begin
      location[i] = '0;
      for (int j = 0; j < MAX_N; j++) begin
        flow_mem[i][j] = '0;
        dist_mem[i][j] = '0;
      end
    end
  end

  function automatic int size_in_use();
    if (num_vars == 0) return 1;
    if (num_vars > MAX_N) return MAX_N;
    return int'(num_vars);
  endfunction

  function automatic qap_result_t assignment_cost();
    qap_result_t       res;
    logic [COST_W-1:0] sum;
    logic [MAX_N-1:0]  covered;
    int                n;
    n = size_in_use();
    res = '0;
    if (bad_location) return res;
    sum = '0;
    covered = '0;
    for (int i = 0; i < n; i++) begin
      covered[location[i]] = 1'b1;
      for (int j = 0; j < n; j++) begin
        sum = sum + COST_W'(dist_mem[i][j]) * COST_W'(flow_mem[location[i]][location[j]]);
      end
    end
    res.cost = sum;
    res.valid = 1'b1;
    if (check_on) begin
      for (int i = 0; i < n; i++) begin
        if (!covered[i]) res.valid = 1'b0;
      end
    end
    return res;
  endfunction

  function automatic void take_beat(qap_beat_t beat, logic lst);
    int n;
    n = size_in_use();
    case (beat.mode)
      MODE_FLOW: flow_mem[beat.row][beat.col] = beat.value;
      MODE_DIST: dist_mem[beat.row][beat.col] = beat.value;
      MODE_ASSIGN: begin
        if (beat.row < n) begin
          if (beat.value < n) location[beat.row] = beat.value[4:0];
          else bad_location = 1'b1;
        end
        if (lst) begin
          pending_costs.insert(pending_costs.size(), assignment_cost());
          bad_location = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin : watch
    qap_result_t want;
    if (!rst_n) begin
      mismatches = 0;
      bad_location = 1'b0;
      num_vars = 6'(NUM_VARS_RST);
      check_on = 1'b1;
      pending_costs.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_costs.size() == 0) begin
          $display("%0t: result beat with nothing expected: cost %0d valid %0b",
                   $time, out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = pending_costs.pop_front();
          if (out_tdata !== want.cost) begin
            $display("%0t: cost expected %0d, actual %0d", $time, want.cost, out_tdata);
            mismatches++;
          end
          if (out_tuser !== want.valid) begin
            $display("%0t: valid_res expected %0b, actual %0b", $time, want.valid, out_tuser);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_addr == REG_NUM_VARS) num_vars = cfg_wdata[5:0];
        else check_on = cfg_wdata[0];
      end
      if (in_tvalid && in_tready) take_beat(qap_beat_t'(in_tdata), in_tlast);
    end
    outstanding = pending_costs.size();
  end

endmodule

>>> tb/qap_cost_evaluator_tb.sv
// Testbench top for the quadratic assignment cost evaluator: fills both matrices, runs
// directed and random assignment sequences under several sizes, and reports the verdict.
// Depends on qap_pkg, the evaluator RTL and qap_cost_evaluator_monitor.
module qap_cost_evaluator_tb
  import qap_pkg::*;
;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         FILL_N = 12;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic                  cfg_addr = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic                  in_tlast = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [COST_W-1:0]     out_tdata;
  logic                  out_tuser;
  int                    mismatches;
  int                    outstanding;
  int                    results_taken = 0;
  int                    items_sent = 0;

  always #5 clk = ~clk;

  qap_cost_evaluator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  qap_cost_evaluator_monitor cost_monitor (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) results_taken <= results_taken + 1;
  end

  task automatic send_item(input logic [1:0] m, input int r, input int c, input int v,
                           input bit lst);
    bit steady;
    steady = items_sent >= 150 && items_sent < 300;
    if (!steady && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, v[15:0], c[4:0], r[4:0], m};
    in_tlast <= lst;
    do @(posedge clk); while (!in_tready);
    if (m != MODE_UNUSED) items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_config(input int num, input bit chk);
    cfg_we <= 1'b1;
    cfg_addr <= REG_NUM_VARS;
    cfg_wdata <= num[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_addr <= REG_CHECK_EN;
    cfg_wdata <= CFG_DATA_W'(chk);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_sequence(input int n);
    int loc [32];
    int pos [32];
    int i, j, tmp, kind, cnt;
    for (i = 0; i < 32; i++) begin
      loc[i] = i;
      pos[i] = i;
    end
    for (i = n - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = loc[i];
      loc[i] = loc[j];
      loc[j] = tmp;
      j = $urandom_range(i);
      tmp = pos[i];
      pos[i] = pos[j];
      pos[j] = tmp;
    end
    repeat ($urandom_range(4)) begin
      send_item($urandom_range(1) ? MODE_DIST : MODE_FLOW, $urandom_range(31),
                $urandom_range(31), $urandom_range(65535), $urandom_range(1));
    end
    if ($urandom_range(19) == 0) begin
      send_item(MODE_UNUSED, $urandom_range(31), $urandom_range(31), $urandom_range(65535),
                $urandom_range(1));
    end
    kind = $urandom_range(99);
    cnt = n;
    if (kind >= 70 && kind < 80) begin
      i = $urandom_range(n - 1);
      loc[i] = loc[(i + 1) % n];
    end else if (kind >= 80 && kind < 88) begin
      loc[$urandom_range(n - 1)] = $urandom_range(65535, n);
    end else if (kind >= 88 && kind < 95) begin
      cnt = $urandom_range(1, n);
    end
    for (i = 0; i < cnt; i++) begin
      if (n < 32 && $urandom_range(9) == 0) begin
        send_item(MODE_ASSIGN, $urandom_range(31, n), $urandom_range(31),
                  $urandom_range(65535), 1'b0);
      end
      send_item(MODE_ASSIGN, pos[i], $urandom_range(31), loc[i], i == cnt - 1 && kind < 95);
    end
    if (kind >= 95) begin
      send_item(MODE_ASSIGN, n < 32 ? $urandom_range(31, n) : pos[0], $urandom_range(31),
                $urandom_range(65535), 1'b1);
    end
  endtask

  initial begin : receiver
    int holds;
    holds = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (holds < 2 && out_tvalid && results_taken >= (holds == 0 ? 4 : 32)) begin
        out_tready <= 1'b0;
        repeat (400) @(negedge clk);
        holds++;
      end else if (results_taken >= 12 && results_taken < 28) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= 20);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int num;
    int n_eff;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_config(FILL_N, 1'b1);
    for (int r = 0; r < FILL_N; r++) begin
      for (int c = 0; c < FILL_N; c++) begin
        send_item(MODE_FLOW, r, c, $urandom_range(65535), 1'b0);
        send_item(MODE_DIST, r, c, $urandom_range(65535), 1'b0);
      end
    end
    for (int p = 0; p < FILL_N; p++) send_item(MODE_ASSIGN, p, 0, p, p == FILL_N - 1);

    wait_drained();
    set_config(4, 1'b1);
    send_item(MODE_FLOW, 31, 31, 16'hFFFF, 1'b1);
    send_item(MODE_DIST, 0, 0, 0, 1'b0);
    send_item(MODE_DIST, 3, 2, 16'hFFFF, 1'b0);
    send_item(MODE_UNUSED, 31, 31, 16'hFFFF, 1'b1);
    send_item(MODE_ASSIGN, 0, 0, 3, 1'b0);
    send_item(MODE_ASSIGN, 1, 0, 2, 1'b0);
    send_item(MODE_ASSIGN, 2, 0, 1, 1'b0);
    send_item(MODE_ASSIGN, 3, 0, 0, 1'b1);
    send_item(MODE_ASSIGN, 0, 0, 16'hFFFF, 1'b0);
    send_item(MODE_ASSIGN, 0, 0, 1, 1'b0);
    send_item(MODE_ASSIGN, 1, 0, 0, 1'b1);
    send_item(MODE_ASSIGN, 0, 31, 2, 1'b0);
    send_item(MODE_ASSIGN, 1, 0, 2, 1'b1);
    send_item(MODE_ASSIGN, 31, 0, 0, 1'b1);
    wait_drained();
    set_config(4, 1'b0);
    send_item(MODE_ASSIGN, 1, 0, 2, 1'b1);
    send_item(MODE_ASSIGN, 2, 0, 4, 1'b0);
    send_item(MODE_ASSIGN, 3, 0, 0, 1'b1);
    wait_drained();
    set_config(0, 1'b1);
    send_item(MODE_ASSIGN, 0, 0, 0, 1'b1);
    send_item(MODE_ASSIGN, 1, 0, 0, 1'b1);
    send_item(MODE_ASSIGN, 0, 0, 1, 1'b1);
    wait_drained();
    set_config(63, 1'b1);
    send_item(MODE_ASSIGN, 31, 0, 40, 1'b1);

    items_sent = 0;
    while (items_sent < 240) begin
      wait_drained();
      num = $urandom_range(15);
      if (num < 11) num = $urandom_range(1, 8);
      else if (num < 15) num = $urandom_range(9, FILL_N);
      else num = 0;
      set_config(num, $urandom_range(1));
      n_eff = num == 0 ? 1 : num;
      repeat ($urandom_range(2, 6)) run_sequence(n_eff);
    end

    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (1100) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/qap_pkg.sv
rtl/qap_ram.sv
rtl/qap_mac.sv
rtl/qap_seq.sv
rtl/qap_cost_evaluator.sv
tb/qap_cost_evaluator_monitor.sv
tb/qap_cost_evaluator_tb.sv
